FILE: hdl/pph_pkg.sv
package pph_pkg;

    // command codes on the func field
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_SEND    = 2'd1,
        FUNC_RECEIVE = 2'd2,
        FUNC_ABORT   = 2'd3
    } t_func;

    // result codes
    typedef enum logic [1:0] {
        RES_NONE         = 2'd0,
        RES_SEND_DONE    = 2'd1,
        RES_RECEIVE_DONE = 2'd2,
        RES_TIMEOUT      = 2'd3
    } t_res_code;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_STROBE_SETUP = 2'd0,
        CFG_TX_TIMEOUT   = 2'd1,
        CFG_RX_TIMEOUT   = 2'd2,
        CFG_CTRL_INVERT  = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 24;
    localparam int SETUP_W    = 16;
    localparam int TIMEOUT_W  = 24;
    localparam int CTRL_W     = 4;
    localparam int BYTE_W     = 8;

    localparam logic [SETUP_W-1:0] SETUP_RESET = 16'd50;

    // control mirror bits
    localparam int CT_STROBE_BIT   = 0;
    localparam int CT_AUTOFEED_BIT = 1;

    // remapped status bits
    localparam int ST_BUSY_I_BIT = 7;
    localparam int ST_PTRCLK_BIT = 6;

    typedef struct packed {
        logic [SETUP_W-1:0]   strobe_setup;
        logic [TIMEOUT_W-1:0] tx_timeout;
        logic [TIMEOUT_W-1:0] rx_timeout;
        logic [CTRL_W-1:0]    ctrl_invert;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_pins;
        logic [CTRL_W-1:0] control_pins;
        logic              ready_res;
        t_res_code         result_code;
        logic [BYTE_W-1:0] received_byte;
    } t_result;

    // swap and invert bits 3 and 7, swap bits 4 and 5, low three bits read zero
    function automatic logic [7:0] remap_status(input logic [7:0] s);
        return {~s[3], s[6], s[4], s[5], ~s[7], 3'b000};
    endfunction

    // nibble from remapped status: bits 5..3, plus inverted busy as bit 3
    function automatic logic [3:0] status_nibble(input logic [7:0] st);
        return {~st[7], st[5:3]};
    endfunction

endpackage

FILE: hdl/pph_if.sv
interface pph_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [pph_pkg::BYTE_W-1:0] send_byte;
    logic [pph_pkg::BYTE_W-1:0] status_pins;

    modport source (output valid, output func, output send_byte, output status_pins,
                    input ready);
    modport sink   (input valid, input func, input send_byte, input status_pins,
                    output ready);
endinterface

interface pph_out_if;
    logic                       valid;
    logic                       ready;
    logic [pph_pkg::BYTE_W-1:0] data_pins;
    logic [pph_pkg::CTRL_W-1:0] control_pins;
    logic                       ready_res;
    logic [1:0]                 result_code;
    logic [pph_pkg::BYTE_W-1:0] received_byte;

    modport source (output valid, output data_pins, output control_pins,
                    output ready_res, output result_code, output received_byte,
                    input ready);
    modport sink   (input valid, input data_pins, input control_pins,
                    input ready_res, input result_code, input received_byte,
                    output ready);
endinterface

FILE: hdl/pph_cfg.sv
module pph_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [pph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pph_pkg::t_cfg                  o_cfg
);
    import pph_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_setup <= SETUP_RESET;
            r_cfg.tx_timeout   <= '0;
            r_cfg.rx_timeout   <= '0;
            r_cfg.ctrl_invert  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STROBE_SETUP: r_cfg.strobe_setup <= i_cfg_data[SETUP_W-1:0];
                CFG_TX_TIMEOUT:   r_cfg.tx_timeout   <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_RX_TIMEOUT:   r_cfg.rx_timeout   <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_CTRL_INVERT:  r_cfg.ctrl_invert  <= i_cfg_data[CTRL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/pph_engine.sv
module pph_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_func,
    input  logic [pph_pkg::BYTE_W-1:0] i_send_byte,
    input  logic [pph_pkg::BYTE_W-1:0] i_status_pins,
    input  pph_pkg::t_cfg              i_cfg,
    output pph_pkg::t_result           o_result
);
    import pph_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_WAIT_RDY = 6'b000010,
        PH_SETUP    = 6'b000100,
        PH_WAIT_BSY = 6'b001000,
        PH_CLK_LOW  = 6'b010000,
        PH_CLK_HIGH = 6'b100000
    } t_phase;

    t_phase               r_phase,  n_phase;
    logic [CTRL_W-1:0]    r_ctrl,   n_ctrl;
    logic [BYTE_W-1:0]    r_data,   n_data;
    logic [SETUP_W-1:0]   r_delay,  n_delay;
    logic [TIMEOUT_W-1:0] r_wait,   n_wait;
    logic [3:0]           r_lo_nib, n_lo_nib;
    logic [3:0]           r_hi_nib, n_hi_nib;
    logic                 r_second, n_second;

    logic [7:0]           st;
    logic [3:0]           nib;
    logic [SETUP_W-1:0]   delay_inc;
    logic                 tx_expired;
    logic                 rx_expired;
    t_res_code            code;
    logic [BYTE_W-1:0]    rx_byte;

    assign st        = remap_status(i_status_pins);
    assign nib       = status_nibble(st);
    assign delay_inc = r_delay + 1'b1;
    assign tx_expired = (i_cfg.tx_timeout != '0) && (r_wait >= i_cfg.tx_timeout);
    assign rx_expired = (i_cfg.rx_timeout != '0) && (r_wait >= i_cfg.rx_timeout);

    always_comb begin
        n_phase  = r_phase;
        n_ctrl   = r_ctrl;
        n_data   = r_data;
        n_delay  = r_delay;
        n_wait   = r_wait;
        n_lo_nib = r_lo_nib;
        n_hi_nib = r_hi_nib;
        n_second = r_second;
        code     = RES_NONE;
        rx_byte  = '0;

        if (t_func'(i_func) == FUNC_ABORT) begin
            n_phase = PH_IDLE;
            n_ctrl  = '0;
            n_data  = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (t_func'(i_func) == FUNC_SEND) begin
                        n_data  = i_send_byte;
                        n_wait  = '0;
                        n_phase = PH_WAIT_RDY;
                    end else if (t_func'(i_func) == FUNC_RECEIVE) begin
                        n_ctrl[CT_AUTOFEED_BIT] = 1'b1;
                        n_second = 1'b0;
                        n_wait   = '0;
                        n_phase  = PH_CLK_LOW;
                    end
                end
                PH_WAIT_RDY: begin
                    if (st[ST_BUSY_I_BIT]) begin
                        if (i_cfg.strobe_setup == '0) begin
                            n_ctrl[CT_STROBE_BIT] = 1'b1;
                            n_wait  = '0;
                            n_phase = PH_WAIT_BSY;
                        end else begin
                            n_delay = '0;
                            n_phase = PH_SETUP;
                        end
                    end else if (tx_expired) begin
                        code    = RES_TIMEOUT;
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait = r_wait + 1'b1;
                    end
                end
                PH_SETUP: begin
                    n_delay = delay_inc;
                    if (delay_inc >= i_cfg.strobe_setup) begin
                        n_ctrl[CT_STROBE_BIT] = 1'b1;
                        n_wait  = '0;
                        n_phase = PH_WAIT_BSY;
                    end
                end
                PH_WAIT_BSY: begin
                    if (!st[ST_BUSY_I_BIT]) begin
                        n_ctrl[CT_STROBE_BIT] = 1'b0;
                        code    = RES_SEND_DONE;
                        n_phase = PH_IDLE;
                    end else if (tx_expired) begin
                        code    = RES_TIMEOUT;
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait = r_wait + 1'b1;
                    end
                end
                PH_CLK_LOW: begin
                    if (!st[ST_PTRCLK_BIT]) begin
                        if (!r_second) begin
                            n_lo_nib = nib;
                        end else begin
                            n_hi_nib = nib;
                        end
                        n_ctrl[CT_AUTOFEED_BIT] = 1'b0;
                        n_wait  = '0;
                        n_phase = PH_CLK_HIGH;
                    end else if (rx_expired) begin
                        code    = RES_TIMEOUT;
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait = r_wait + 1'b1;
                    end
                end
                PH_CLK_HIGH: begin
                    if (st[ST_PTRCLK_BIT]) begin
                        if (!r_second) begin
                            n_second = 1'b1;
                            n_ctrl[CT_AUTOFEED_BIT] = 1'b1;
                            n_wait  = '0;
                            n_phase = PH_CLK_LOW;
                        end else begin
                            rx_byte = {r_hi_nib, r_lo_nib};
                            code    = RES_RECEIVE_DONE;
                            n_phase = PH_IDLE;
                        end
                    end else if (rx_expired) begin
                        code    = RES_TIMEOUT;
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait = r_wait + 1'b1;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ctrl   <= '0;
            r_data   <= '0;
            r_delay  <= '0;
            r_wait   <= '0;
            r_lo_nib <= '0;
            r_hi_nib <= '0;
            r_second <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ctrl   <= n_ctrl;
            r_data   <= n_data;
            r_delay  <= n_delay;
            r_wait   <= n_wait;
            r_lo_nib <= n_lo_nib;
            r_hi_nib <= n_hi_nib;
            r_second <= n_second;
        end
    end

    always_comb begin
        o_result.data_pins     = n_data;
        o_result.control_pins  = n_ctrl ^ i_cfg.ctrl_invert;
        o_result.ready_res     = (n_phase == PH_IDLE);
        o_result.result_code   = code;
        o_result.received_byte = rx_byte;
    end

endmodule

FILE: hdl/pph_out_buf.sv
module pph_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pph_pkg::t_result i_result,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output pph_pkg::t_result o_result
);
    import pph_pkg::*;

    logic    r_out_v;
    logic    r_skd_v;
    t_result r_out;
    t_result r_skd;
    logic    drain;

    assign drain      = !r_out_v || i_ready;
    assign o_can_push = !r_skd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (drain) begin
            if (r_skd_v) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skd_v ? r_skd : i_result;
        end else if (i_push) begin
            r_skd <= i_result;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

FILE: hdl/parallel_port_host_handshake.sv
// Host side of a parallel-port link: compatibility-mode byte send and nibble-mode
// byte receive, advanced by one request per clock while input ready is high. Each
// request carries a command (tick, start send, start receive, abort) and the raw
// status pins sampled for that tick, and yields exactly one result with the data
// pins, the control pins after the inversion mask, an idle flag, a result code and
// the received byte. The handshake state is updated in the accept cycle and the
// result is held in a two-deep output register, so input ready drops only when two
// results are waiting downstream. Setup delay and both timeouts count requests, not
// clocks; a timeout of zero waits forever. The user must write the configuration
// through the simple write port only while the block is idle; the block does not enforce it.
module parallel_port_host_handshake (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pph_in_if.sink                         i_in,
    pph_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [pph_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pph_pkg::*;

    t_cfg    cfg;
    t_result eng_result;
    t_result buf_result;
    logic    can_push;
    logic    accept;

    // a request is taken whenever the skid slot is free
    assign i_in.ready = can_push;
    assign accept     = i_in.valid && can_push;

    // register file: setup ticks, two timeouts, control inversion mask
    pph_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // send/receive state machine, steps once per accepted request
    pph_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_in.func),
        .i_send_byte   (i_in.send_byte),
        .i_status_pins (i_in.status_pins),
        .i_cfg         (cfg),
        .o_result      (eng_result)
    );

    // output register plus skid slot
    pph_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (eng_result),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (buf_result)
    );

    assign o_out.data_pins     = buf_result.data_pins;
    assign o_out.control_pins  = buf_result.control_pins;
    assign o_out.ready_res     = buf_result.ready_res;
    assign o_out.result_code   = buf_result.result_code;
    assign o_out.received_byte = buf_result.received_byte;

endmodule

FILE: bench/parallel_port_host_handshake_test.sv
module parallel_port_host_handshake_test;

    import pph_pkg::*;

    // phases of the host handshake as the bench tracks them
    typedef enum logic [2:0] {
        HS_IDLE,
        HS_WAIT_READY,
        HS_SETUP,
        HS_WAIT_BUSY,
        HS_CLK_LOW,
        HS_CLK_HIGH
    } t_hs_phase;

    // tracks the host link state, holds the pin results each request should give
    class host_link_tracker;
        logic [SETUP_W-1:0]   setup_ticks;
        logic [TIMEOUT_W-1:0] tx_limit;
        logic [TIMEOUT_W-1:0] rx_limit;
        logic [CTRL_W-1:0]    invert_mask;

        t_hs_phase            phase;
        logic [CTRL_W-1:0]    ctrl;
        logic [BYTE_W-1:0]    data;
        logic [SETUP_W-1:0]   delay_cnt;
        logic [TIMEOUT_W-1:0] wait_cnt;
        logic [3:0]           lo_nib;
        logic [3:0]           hi_nib;
        bit                   on_high_nib;

        t_result pin_results_q[$];
        int      errors;
        int      n_sends;
        int      n_receives;
        int      n_timeouts;
        int      n_aborts;

        function new();
            setup_ticks = SETUP_RESET;
            tx_limit    = '0;
            rx_limit    = '0;
            invert_mask = '0;
            phase       = HS_IDLE;
            ctrl        = '0;
            data        = '0;
            delay_cnt   = '0;
            wait_cnt    = '0;
            lo_nib      = '0;
            hi_nib      = '0;
            on_high_nib = 1'b0;
            errors      = 0;
            n_sends     = 0;
            n_receives  = 0;
            n_timeouts  = 0;
            n_aborts    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_STROBE_SETUP: setup_ticks = value[SETUP_W-1:0];
                CFG_TX_TIMEOUT:   tx_limit    = value[TIMEOUT_W-1:0];
                CFG_RX_TIMEOUT:   rx_limit    = value[TIMEOUT_W-1:0];
                CFG_CTRL_INVERT:  invert_mask = value[CTRL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pin_results_q.size();
        endfunction

        // unmet wait tick: out of time, or count it
        function bit wait_ran_out(logic [TIMEOUT_W-1:0] limit);
            if (limit != '0 && wait_cnt >= limit)
                return 1'b1;
            wait_cnt = wait_cnt + 1'b1;
            return 1'b0;
        endfunction

        function void raise_strobe();
            ctrl[CT_STROBE_BIT] = 1'b1;
            wait_cnt = '0;
            phase = HS_WAIT_BUSY;
        endfunction

        function void note_request(t_func f, logic [BYTE_W-1:0] byte_in,
                                   logic [BYTE_W-1:0] raw);
            logic [7:0]        st;
            t_res_code         code;
            logic [BYTE_W-1:0] rx;
            t_result           r;
            st   = {~raw[3], raw[6], raw[4], raw[5], ~raw[7], 3'b000};
            code = RES_NONE;
            rx   = '0;
            if (f == FUNC_ABORT) begin
                phase = HS_IDLE;
                ctrl  = '0;
                data  = '0;
                n_aborts++;
            end else begin
                case (phase)
                    HS_IDLE: begin
                        if (f == FUNC_SEND) begin
                            data     = byte_in;
                            wait_cnt = '0;
                            phase    = HS_WAIT_READY;
                        end else if (f == FUNC_RECEIVE) begin
                            ctrl[CT_AUTOFEED_BIT] = 1'b1;
                            on_high_nib = 1'b0;
                            wait_cnt    = '0;
                            phase       = HS_CLK_LOW;
                        end
                    end
                    HS_WAIT_READY: begin
                        if (st[ST_BUSY_I_BIT]) begin
                            if (setup_ticks == '0) begin
                                raise_strobe();
                            end else begin
                                delay_cnt = '0;
                                phase     = HS_SETUP;
                            end
                        end else if (wait_ran_out(tx_limit)) begin
                            code = RES_TIMEOUT;
                        end
                    end
                    HS_SETUP: begin
                        delay_cnt = delay_cnt + 1'b1;
                        if (delay_cnt >= setup_ticks)
                            raise_strobe();
                    end
                    HS_WAIT_BUSY: begin
                        if (!st[ST_BUSY_I_BIT]) begin
                            ctrl[CT_STROBE_BIT] = 1'b0;
                            code = RES_SEND_DONE;
                        end else if (wait_ran_out(tx_limit)) begin
                            code = RES_TIMEOUT;
                        end
                    end
                    HS_CLK_LOW: begin
                        if (!st[ST_PTRCLK_BIT]) begin
                            if (on_high_nib)
                                hi_nib = {~st[7], st[5:3]};
                            else
                                lo_nib = {~st[7], st[5:3]};
                            ctrl[CT_AUTOFEED_BIT] = 1'b0;
                            wait_cnt = '0;
                            phase    = HS_CLK_HIGH;
                        end else if (wait_ran_out(rx_limit)) begin
                            code = RES_TIMEOUT;
                        end
                    end
                    HS_CLK_HIGH: begin
                        if (st[ST_PTRCLK_BIT]) begin
                            if (!on_high_nib) begin
                                on_high_nib = 1'b1;
                                ctrl[CT_AUTOFEED_BIT] = 1'b1;
                                wait_cnt = '0;
                                phase    = HS_CLK_LOW;
                            end else begin
                                rx   = {hi_nib, lo_nib};
                                code = RES_RECEIVE_DONE;
                            end
                        end else if (wait_ran_out(rx_limit)) begin
                            code = RES_TIMEOUT;
                        end
                    end
                    default: phase = HS_IDLE;
                endcase
            end
            // any completion or timeout ends the exchange
            if (code != RES_NONE)
                phase = HS_IDLE;
            case (code)
                RES_SEND_DONE:    n_sends++;
                RES_RECEIVE_DONE: n_receives++;
                RES_TIMEOUT:      n_timeouts++;
                default: ;
            endcase
            r.data_pins     = data;
            r.control_pins  = ctrl ^ invert_mask;
            r.ready_res     = (phase == HS_IDLE);
            r.result_code   = code;
            r.received_byte = rx;
            pin_results_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pin_results_q.size() == 0) begin
                $error("result with no request waiting: %h", got);
                errors++;
                return;
            end
            want = pin_results_q.pop_front();
            if (got.data_pins !== want.data_pins) begin
                $error("data_pins: expected %0h, actual %0h", want.data_pins, got.data_pins);
                errors++;
            end
            if (got.control_pins !== want.control_pins) begin
                $error("control_pins: expected %0h, actual %0h",
                       want.control_pins, got.control_pins);
                errors++;
            end
            if (got.ready_res !== want.ready_res) begin
                $error("ready_res: expected %0b, actual %0b", want.ready_res, got.ready_res);
                errors++;
            end
            if (got.result_code !== want.result_code) begin
                $error("result_code: expected %0d, actual %0d",
                       want.result_code, got.result_code);
                errors++;
            end
            if (got.received_byte !== want.received_byte) begin
                $error("received_byte: expected %0h, actual %0h",
                       want.received_byte, got.received_byte);
                errors++;
            end
        endfunction
    endclass

    localparam int ITEM_GOAL   = 1700;
    localparam int HOLD_CYCLES = 300;    // long output hold-off to fill the block
    localparam int STALL_LIMIT = 2000;   // cycles with no request or result moving

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pph_in_if  in_if();
    pph_out_if out_if();

    parallel_port_host_handshake u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    host_link_tracker link_model = new();

    // knobs for the sender and receiver idling, and the one-shot hold-off
    bit      tx_idling = 1'b1;
    bit      rx_idling = 1'b1;
    bit      hold_request = 1'b0;
    int      n_items = 0;
    int      n_holds = 0;
    int      stall_cycles = 0;
    t_result seen_result;

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // offer one request, wait for it to be taken, then log it in the model
    task automatic push_request(t_func f, logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] st);
        if (tx_idling && $urandom_range(99) < 25) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.func        <= f;
        in_if.send_byte   <= b;
        in_if.status_pins <= st;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        link_model.note_request(f, b, st);
        n_items++;
    endtask

    // write all four registers back to back, block is idle here
    task automatic program_regs(logic [SETUP_W-1:0] setup_v, logic [TIMEOUT_W-1:0] tx_v,
                                logic [TIMEOUT_W-1:0] rx_v, logic [CTRL_W-1:0] mask_v);
        logic [CFG_DATA_W-1:0] vals [4];
        t_cfg_idx              idx;
        vals[CFG_STROBE_SETUP] = CFG_DATA_W'(setup_v);
        vals[CFG_TX_TIMEOUT]   = CFG_DATA_W'(tx_v);
        vals[CFG_RX_TIMEOUT]   = CFG_DATA_W'(rx_v);
        vals[CFG_CTRL_INVERT]  = CFG_DATA_W'(mask_v);
        idx = CFG_STROBE_SETUP;
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[idx];
            @(posedge i_clk);
            link_model.set_reg(idx, vals[idx]);
            idx = idx.next();
        end while (idx != CFG_STROBE_SETUP);
        i_cfg_we <= 1'b0;
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain();
        in_if.valid <= 1'b0;
        while (link_model.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // park the handshake in idle before touching the registers
    task automatic settle();
        push_request(FUNC_ABORT, BYTE_W'($urandom), BYTE_W'($urandom));
        drain();
    endtask

    // one send or receive driven by a device that meets each wait at met_pct,
    // with stray ticks, ignored starts and aborts mixed in at noise_pct
    task automatic one_exchange(t_func start, int noise_pct);
        int                met_pct;
        int                r;
        bit                met;
        t_func             f;
        logic [BYTE_W-1:0] st;
        met_pct = $urandom_range(20, 90);
        if ($urandom_range(99) < noise_pct)
            push_request($urandom_range(1) ? FUNC_TICK : FUNC_ABORT,
                         BYTE_W'($urandom), BYTE_W'($urandom));
        push_request(start, BYTE_W'($urandom), BYTE_W'($urandom));
        while (link_model.phase != HS_IDLE) begin
            r = $urandom_range(99);
            if (r < noise_pct / 4)
                f = FUNC_ABORT;
            else if (r < noise_pct)
                f = $urandom_range(1) ? FUNC_SEND : FUNC_RECEIVE;
            else
                f = FUNC_TICK;
            st  = BYTE_W'($urandom);
            met = ($urandom_range(99) < met_pct);
            // raw bit 3 low means not busy, raw bit 6 is the printer clock
            case (link_model.phase)
                HS_WAIT_READY: st[3] = !met;
                HS_WAIT_BUSY:  st[3] = met;
                HS_CLK_LOW:    st[6] = !met;
                HS_CLK_HIGH:   st[6] = met;
                default: ;
            endcase
            push_request(f, BYTE_W'($urandom), st);
        end
    endtask

    task automatic run_exchanges(int n, int noise_pct);
        repeat (n)
            one_exchange($urandom_range(1) ? FUNC_SEND : FUNC_RECEIVE, noise_pct);
    endtask

    // short hand-written walk through every command and corner
    task automatic directed_walk();
        push_request(FUNC_TICK, 8'h00, 8'h00);       // idle tick, all pins low
        push_request(FUNC_TICK, 8'hFF, 8'hFF);       // idle tick, all pins high
        push_request(FUNC_SEND, 8'hFF, 8'h08);       // start send
        push_request(FUNC_TICK, 8'h00, 8'h08);       // device busy
        push_request(FUNC_TICK, 8'h00, 8'h00);       // not busy, zero setup strobes now
        push_request(FUNC_TICK, 8'h00, 8'h08);       // busy again, send done
        push_request(FUNC_SEND, 8'h00, 8'h00);
        push_request(FUNC_TICK, 8'h00, 8'h00);       // strobe
        repeat (3)
            push_request(FUNC_TICK, 8'h00, 8'h00);   // never busy: timeout, strobe stays
        push_request(FUNC_RECEIVE, 8'hA5, 8'h40);    // start receive
        push_request(FUNC_TICK, 8'h00, 8'h40);       // clock still high
        push_request(FUNC_TICK, 8'h00, 8'h98);       // clock low, low nibble
        push_request(FUNC_TICK, 8'h00, 8'h40);       // clock high
        push_request(FUNC_TICK, 8'h00, 8'h28);       // clock low, high nibble
        push_request(FUNC_TICK, 8'h00, 8'hC0);       // clock high, byte done
        push_request(FUNC_SEND, 8'h5A, 8'h08);
        push_request(FUNC_RECEIVE, 8'h00, 8'h00);    // receive start mid send is ignored
        push_request(FUNC_ABORT, 8'h00, 8'h00);      // abort mid send clears pins
        push_request(FUNC_RECEIVE, 8'h00, 8'h40);
        push_request(FUNC_TICK, 8'h00, 8'h00);       // clock low
        repeat (3)
            push_request(FUNC_TICK, 8'h00, 8'h00);   // clock never rises: timeout
        push_request(FUNC_ABORT, 8'hFF, 8'hFF);      // abort while idle
    endtask

    // receiver side: random stalls, or a long hold-off when asked
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                n_holds++;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idling) begin
                out_if.ready <= ($urandom_range(99) >= 25);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen_result.data_pins     = out_if.data_pins;
            seen_result.control_pins  = out_if.control_pins;
            seen_result.ready_res     = out_if.ready_res;
            seen_result.result_code   = t_res_code'(out_if.result_code);
            seen_result.received_byte = out_if.received_byte;
            link_model.check_result(seen_result);
        end
    end

    // watchdog: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // every input known from time zero, reset asserted first
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_STROBE_SETUP;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.func        <= FUNC_TICK;
        in_if.send_byte   <= '0;
        in_if.status_pins <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: setup of 50 requests, no timeouts, no inversion
        run_exchanges(3, 0);
        settle();

        // zero setup, short timeouts, plain control pins
        program_regs(16'd0, 24'd2, 24'd2, 4'h0);
        directed_walk();
        drain();

        program_regs(16'd1, 24'd1, 24'd1, 4'h5);
        run_exchanges(40, 8);
        settle();

        program_regs(16'd3, 24'd0, 24'd4, 4'hA);
        run_exchanges(40, 8);
        settle();

        // stretch with no idling on either side; the receiver also holds off
        // for a long while so the block fills and stalls its input
        tx_idling    = 1'b0;
        rx_idling    = 1'b0;
        hold_request = 1'b1;
        run_exchanges(40, 8);
        settle();
        tx_idling = 1'b1;
        rx_idling = 1'b1;

        // no timeouts at all, waits end only when the device answers
        program_regs(16'd2, 24'd0, 24'd0, 4'h3);
        run_exchanges(20, 8);
        settle();

        while (n_items < ITEM_GOAL) begin
            program_regs(SETUP_W'($urandom_range(0, 6)), TIMEOUT_W'($urandom_range(0, 8)),
                         TIMEOUT_W'($urandom_range(0, 8)), CTRL_W'($urandom_range(0, 15)));
            run_exchanges(15, 8);
            settle();
        end

        // widest setup and timeouts: a send parked in its setup delay, then
        // aborted, and one receive
        program_regs(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF);
        push_request(FUNC_SEND, 8'hC3, 8'h00);
        repeat (24)
            push_request(FUNC_TICK, 8'h00, 8'h00);   // not busy, still counting setup
        push_request(FUNC_ABORT, 8'h00, 8'h00);
        one_exchange(FUNC_RECEIVE, 0);
        settle();

        // let any stray result show up before the verdict
        repeat (16) @(posedge i_clk);
        $display("run covered %0d requests: %0d sends, %0d receives, %0d timeouts, %0d aborts",
                 n_items, link_model.n_sends, link_model.n_receives,
                 link_model.n_timeouts, link_model.n_aborts);
        $display("with %0d long output hold-off(s) and %0d mismatches",
                 n_holds, link_model.errors);
        if (link_model.errors == 0 && link_model.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
